[rtl/core/aec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package aec_pkg;

  localparam int unsigned CHANNELS_DEF = 4;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned PHASE_W  = 10;
  localparam int unsigned MUTE_W   = 16;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned LVL_W    = 2;
  localparam int unsigned RPT_W    = 2;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 16;

  localparam logic [PHASE_W-1:0] BEEP_MS = 10'd200;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INC  = 3'd0,
    ACT_DEC  = 3'd1,
    ACT_CLR  = 3'd2,
    ACT_TICK = 3'd3,
    ACT_MUTE = 3'd4
  } action_e;

  typedef enum logic [LVL_W-1:0] {
    LVL_OK   = 2'd0,
    LVL_WARN = 2'd1,
    LVL_ERR  = 2'd2
  } level_e;

  typedef enum logic [RPT_W-1:0] {
    RPT_NONE = 2'd0,
    RPT_INFO = 2'd1,
    RPT_WARN = 2'd2,
    RPT_ERR  = 2'd3
  } report_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARN_RISE  = 3'd0,
    CFG_WARN_FALL  = 3'd1,
    CFG_ERROR_RISE = 3'd2,
    CFG_ERROR_FALL = 3'd3,
    CFG_CEILING    = 3'd4
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] WARN_RISE_RST  = 8'd3;
  localparam logic [CFG_W-1:0] WARN_FALL_RST  = 8'd1;
  localparam logic [CFG_W-1:0] ERROR_RISE_RST = 8'd6;
  localparam logic [CFG_W-1:0] ERROR_FALL_RST = 8'd3;
  localparam logic [CFG_W-1:0] CEILING_RST    = 8'd10;

  typedef struct packed {
    logic [CFG_W-1:0] warn_rise;
    logic [CFG_W-1:0] warn_fall;
    logic [CFG_W-1:0] error_rise;
    logic [CFG_W-1:0] error_fall;
    logic [CFG_W-1:0] count_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAN_W-1:0]   channel;
    logic [PHASE_W-1:0]  millis_phase;
    logic [MUTE_W-1:0]   mute_ticks;
  } item_t;

  typedef struct packed {
    logic              buzzer_on;
    report_e           report_kind;
    logic [CNT_W-1:0]  count;
    level_e            level;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/alarm_escalation_counter.sv]
`timescale 1ns / 1ps
`default_nettype none

// per-channel alarm escalation with a shared buzzer. each request passes an
// input register, then combinational logic that reads and updates the channel
// file, the alarm level, the mute countdown and the buzzer, and lands in the
// result register; while the result side is ready the block takes one request
// per clock, and a result held by m_axis_tready low stalls both stages.
// channel, level and count state live in flip-flops, so back-to-back
// requests to the same channel see each other.

module alarm_escalation_counter #(
  parameter int unsigned CHANNELS = aec_pkg::CHANNELS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // action[2:0], channel[4:3], millis_phase[14:5], mute_ticks[30:15], zero[31]
  input  wire [aec_pkg::S_DATA_W-1:0]      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // level[1:0], count[9:2], report_kind[11:10], buzzer_on[12], zero[15:13]
  output logic [aec_pkg::M_DATA_W-1:0]     m_axis_tdata,
  input  wire                              cfg_we_i,
  input  wire [aec_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [aec_pkg::CFG_W-1:0]         cfg_wdata_i
);

  aec_pkg::cfg_t     cfg_q;
  aec_pkg::item_t    in_q;
  logic              in_valid_q;
  aec_pkg::result_t  out_q;
  aec_pkg::result_t  out_d;
  logic              out_valid_q;
  logic              adv;

  logic [aec_pkg::CNT_W-1:0]  counts_q [CHANNELS];
  logic [aec_pkg::CNT_W-1:0]  counts_d [CHANNELS];
  aec_pkg::level_e            levels_q [CHANNELS];
  aec_pkg::level_e            levels_d [CHANNELS];
  aec_pkg::level_e            alarm_q, alarm_d;
  logic [aec_pkg::MUTE_W-1:0] mute_q, mute_d;
  logic                       buzzer_q, buzzer_d;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.buzzer_on, out_q.report_kind, out_q.count, out_q.level};

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn_rise     <= aec_pkg::WARN_RISE_RST;
      cfg_q.warn_fall     <= aec_pkg::WARN_FALL_RST;
      cfg_q.error_rise    <= aec_pkg::ERROR_RISE_RST;
      cfg_q.error_fall    <= aec_pkg::ERROR_FALL_RST;
      cfg_q.count_ceiling <= aec_pkg::CEILING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aec_pkg::CFG_WARN_RISE:  cfg_q.warn_rise     <= cfg_wdata_i;
        aec_pkg::CFG_WARN_FALL:  cfg_q.warn_fall     <= cfg_wdata_i;
        aec_pkg::CFG_ERROR_RISE: cfg_q.error_rise    <= cfg_wdata_i;
        aec_pkg::CFG_ERROR_FALL: cfg_q.error_fall    <= cfg_wdata_i;
        aec_pkg::CFG_CEILING:    cfg_q.count_ceiling <= cfg_wdata_i;
        default:                 cfg_q               <= cfg_q;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.action       <= s_axis_tdata[2:0];
      in_q.channel      <= s_axis_tdata[4:3];
      in_q.millis_phase <= s_axis_tdata[14:5];
      in_q.mute_ticks   <= s_axis_tdata[30:15];
    end
  end

  aec_step #(
    .CHANNELS (CHANNELS)
  ) u_step (
    .cfg_i    (cfg_q),
    .item_i   (in_q),
    .counts_i (counts_q),
    .levels_i (levels_q),
    .alarm_i  (alarm_q),
    .mute_i   (mute_q),
    .buzzer_i (buzzer_q),
    .counts_o (counts_d),
    .levels_o (levels_d),
    .alarm_o  (alarm_d),
    .mute_o   (mute_d),
    .buzzer_o (buzzer_d),
    .result_o (out_d)
  );

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        counts_q[i] <= '0;
        levels_q[i] <= aec_pkg::LVL_OK;
      end
      alarm_q  <= aec_pkg::LVL_OK;
      mute_q   <= '0;
      buzzer_q <= 1'b0;
    end else if (adv) begin
      counts_q <= counts_d;
      levels_q <= levels_d;
      alarm_q  <= alarm_d;
      mute_q   <= mute_d;
      buzzer_q <= buzzer_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/aec_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module aec_step #(
  parameter int unsigned CHANNELS = aec_pkg::CHANNELS_DEF
) (
  input  aec_pkg::cfg_t                       cfg_i,
  input  aec_pkg::item_t                      item_i,
  input  logic [aec_pkg::CNT_W-1:0]           counts_i [CHANNELS],
  input  aec_pkg::level_e                     levels_i [CHANNELS],
  input  aec_pkg::level_e                     alarm_i,
  input  logic [aec_pkg::MUTE_W-1:0]          mute_i,
  input  logic                                buzzer_i,
  output logic [aec_pkg::CNT_W-1:0]           counts_o [CHANNELS],
  output aec_pkg::level_e                     levels_o [CHANNELS],
  output aec_pkg::level_e                     alarm_o,
  output logic [aec_pkg::MUTE_W-1:0]          mute_o,
  output logic                                buzzer_o,
  output aec_pkg::result_t                    result_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [IDX_W-1:0]          idx;
  logic                      ch_ok;
  logic [aec_pkg::CNT_W-1:0] cur_cnt;
  aec_pkg::level_e           cur_lvl;
  logic [aec_pkg::CNT_W:0]   cnt_inc;
  logic [aec_pkg::CNT_W-1:0] cnt_sat;
  logic [aec_pkg::CNT_W-1:0] cnt_dec;
  aec_pkg::level_e           new_lvl;
  aec_pkg::report_e          report;

  assign idx     = IDX_W'(item_i.channel);
  assign ch_ok   = 32'(item_i.channel) < CHANNELS;
  assign cur_cnt = counts_i[idx];
  assign cur_lvl = levels_i[idx];
  assign cnt_inc = {1'b0, cur_cnt} + 9'd1;
  assign cnt_sat = (cnt_inc > {1'b0, cfg_i.count_ceiling}) ? cfg_i.count_ceiling
                                                           : cnt_inc[aec_pkg::CNT_W-1:0];
  assign cnt_dec = (cur_cnt == '0) ? '0 : cur_cnt - 8'd1;

  always_comb begin
    counts_o = counts_i;
    levels_o = levels_i;
    alarm_o  = alarm_i;
    mute_o   = mute_i;
    buzzer_o = buzzer_i;
    new_lvl  = cur_lvl;
    report   = aec_pkg::RPT_NONE;
    case (item_i.action)
      aec_pkg::ACT_INC: begin
        if (ch_ok) begin
          case (cur_lvl)
            aec_pkg::LVL_OK: begin
              if (cnt_sat >= cfg_i.warn_rise) begin
                new_lvl = aec_pkg::LVL_WARN;
                if (alarm_i != aec_pkg::LVL_ERR) alarm_o = aec_pkg::LVL_WARN;
              end
            end
            aec_pkg::LVL_WARN: begin
              if (cnt_sat >= cfg_i.error_rise) begin
                new_lvl = aec_pkg::LVL_ERR;
                alarm_o = aec_pkg::LVL_ERR;
              end else begin
                alarm_o = aec_pkg::LVL_WARN;
              end
            end
            default: alarm_o = aec_pkg::LVL_ERR;
          endcase
          counts_o[idx] = cnt_sat;
          levels_o[idx] = new_lvl;
          case (new_lvl)
            aec_pkg::LVL_WARN: report = aec_pkg::RPT_WARN;
            aec_pkg::LVL_ERR:  report = aec_pkg::RPT_ERR;
            default:           report = aec_pkg::RPT_INFO;
          endcase
        end
      end
      aec_pkg::ACT_DEC: begin
        if (ch_ok) begin
          case (cur_lvl)
            aec_pkg::LVL_WARN: if (cnt_dec < cfg_i.warn_fall) new_lvl = aec_pkg::LVL_OK;
            aec_pkg::LVL_ERR:  if (cnt_dec < cfg_i.error_fall) new_lvl = aec_pkg::LVL_WARN;
            default:           new_lvl = cur_lvl;
          endcase
          counts_o[idx] = cnt_dec;
          levels_o[idx] = new_lvl;
          case (new_lvl)
            aec_pkg::LVL_WARN: report = aec_pkg::RPT_WARN;
            aec_pkg::LVL_ERR:  report = aec_pkg::RPT_ERR;
            default:           report = aec_pkg::RPT_NONE;
          endcase
        end
      end
      aec_pkg::ACT_CLR: begin
        if (ch_ok) begin
          counts_o[idx] = '0;
          levels_o[idx] = aec_pkg::LVL_OK;
        end
      end
      aec_pkg::ACT_TICK: begin
        if (mute_i != '0) begin
          buzzer_o = 1'b0;
          mute_o   = mute_i - 16'd1;
          alarm_o  = aec_pkg::LVL_OK;
        end else begin
          case (alarm_i)
            aec_pkg::LVL_WARN: buzzer_o = (item_i.millis_phase < aec_pkg::BEEP_MS);
            aec_pkg::LVL_OK:   buzzer_o = 1'b0;
            default:           buzzer_o = 1'b1;
          endcase
        end
      end
      aec_pkg::ACT_MUTE: mute_o = item_i.mute_ticks;
      default: report = aec_pkg::RPT_NONE;
    endcase
  end

  always_comb begin
    result_o.buzzer_on   = buzzer_o;
    result_o.report_kind = report;
    result_o.count       = ch_ok ? counts_o[idx] : '0;
    result_o.level       = ch_ok ? levels_o[idx] : aec_pkg::LVL_OK;
  end

endmodule

`default_nettype wire

[rtl/core/aec_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module aec_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tready,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [aec_pkg::M_DATA_W-1:0]  m_axis_tdata
);

  logic [aec_pkg::LVL_W-1:0] lvl;
  logic [aec_pkg::RPT_W-1:0] rpt;

  assign lvl = m_axis_tdata[1:0];
  assign rpt = m_axis_tdata[11:10];

  // error report only for a channel in error
  a_err_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rpt == aec_pkg::RPT_ERR |-> lvl == aec_pkg::LVL_ERR)
    else $error("error report without error level");

  // warning report only for a channel in warning
  a_warn_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rpt == aec_pkg::RPT_WARN |-> lvl == aec_pkg::LVL_WARN)
    else $error("warning report without warning level");

  // info report only for a channel still ok
  a_info_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rpt == aec_pkg::RPT_INFO |-> lvl == aec_pkg::LVL_OK)
    else $error("info report with raised level");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // input side only stalls behind a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without result back-pressure");

endmodule

bind alarm_escalation_counter aec_checker u_aec_checker (.*);

`default_nettype wire
